FILE: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and controller/datapath interface types for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int          DATA_W        = 32;   // width of every stream field
    localparam int          WIDTH_DEFAULT = 32;   // operand width
    localparam logic [31:0] MODULUS_RESET = 32'd7;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture operands, clear product, acc = 1
        logic mul_init;   // start a modular product of acc and (acc or base)
        logic mul_base;   // multiplier is the reduced base, else acc
        logic step;       // one double-and-add step
        logic base_wr;    // reduced base <= product
        logic acc_wr;     // acc <= product
        logic exp_shift;  // advance to next exponent bit
        logic res_wr;     // output register <= result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic exp_msb;    // current exponent bit
    } t_dp_sts;

endpackage

FILE: rtl/modexp_dp.sv
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: modulus register, operand registers and a shared bit-serial
// double-and-add modular step used both for base reduction and products.
// ----------------------------------------------------------------------------
module modexp_dp #(
    parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [modexp_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic [modexp_pkg::DATA_W-1:0] i_base,
    input  logic [modexp_pkg::DATA_W-1:0] i_exp,
    input  modexp_pkg::t_dp_cmd          i_cmd,
    output modexp_pkg::t_dp_sts          o_sts,
    output logic [modexp_pkg::DATA_W-1:0] o_res
);
    import modexp_pkg::*;

    localparam int SW = WIDTH + 2;

    logic [DATA_W-1:0] r_modulus;
    logic [WIDTH-1:0]  r_m;
    logic [WIDTH-1:0]  r_base;
    logic [WIDTH-1:0]  r_acc;
    logic [WIDTH-1:0]  r_exp;
    logic [WIDTH-1:0]  r_prod;
    logic [WIDTH-1:0]  r_mplr;
    logic [WIDTH-1:0]  r_mcand;
    logic [DATA_W-1:0] r_res;

    logic [SW-1:0]     w_sum;
    logic [SW-1:0]     w_m1;
    logic [SW-1:0]     w_m2;
    logic [SW-1:0]     w_sub;
    logic [SW-1:0]     w_red;
    logic              w_m_small;

    // 2r + bit*a with r, a < m stays below 3m: at most two subtractions of m
    always_comb begin
        w_sum = {1'b0, r_prod, 1'b0} + (r_mplr[WIDTH-1] ? SW'(r_mcand) : '0);
        w_m1  = SW'(r_m);
        w_m2  = {1'b0, r_m, 1'b0};
        if (w_sum >= w_m2) begin
            w_sub = w_m2;
        end else if (w_sum >= w_m1) begin
            w_sub = w_m1;
        end else begin
            w_sub = '0;
        end
        w_red     = w_sum - w_sub;
        w_m_small = (r_m < WIDTH'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m     <= WIDTH'(r_modulus);
            r_exp   <= WIDTH'(i_exp);
            r_mplr  <= WIDTH'(i_base);
            r_mcand <= WIDTH'(1);   // reduction feeds base bits in one at a time
            r_prod  <= '0;
            r_acc   <= WIDTH'(1);
        end else if (i_cmd.mul_init) begin
            r_prod  <= '0;
            r_mcand <= r_acc;
            r_mplr  <= i_cmd.mul_base ? r_base : r_acc;
        end else if (i_cmd.step) begin
            r_prod  <= w_red[WIDTH-1:0];
            r_mplr  <= {r_mplr[WIDTH-2:0], 1'b0};
        end
        if (i_cmd.base_wr) begin
            r_base <= w_red[WIDTH-1:0];
        end
        if (i_cmd.acc_wr) begin
            r_acc <= w_red[WIDTH-1:0];
        end
        if (i_cmd.exp_shift) begin
            r_exp <= {r_exp[WIDTH-2:0], 1'b0};
        end
        if (i_cmd.res_wr) begin
            r_res <= w_m_small ? '0 : DATA_W'(r_acc);
        end
    end

    assign o_sts.exp_msb = r_exp[WIDTH-1];
    assign o_res         = r_res;

endmodule

FILE: rtl/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction and square-and-multiply over the
// exponent bits, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module modexp_ctrl #(
    parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  modexp_pkg::t_dp_sts i_sts,
    output modexp_pkg::t_dp_cmd o_cmd
);
    import modexp_pkg::*;

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MINIT,
        ST_MRUN,
        ST_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_step_cnt, n_step_cnt;
    logic [CW-1:0] r_bit_cnt, n_bit_cnt;
    logic          r_sq, n_sq;
    logic          r_out_valid, n_out_valid;
    t_dp_cmd       w_cmd;

    always_comb begin
        n_state     = r_state;
        n_step_cnt  = r_step_cnt;
        n_bit_cnt   = r_bit_cnt;
        n_sq        = r_sq;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_step_cnt = CW'(WIDTH - 1);
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                w_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt - 1'b1;
                if (r_step_cnt == '0) begin
                    w_cmd.base_wr = 1'b1;
                    n_bit_cnt     = CW'(WIDTH - 1);
                    n_sq          = 1'b1;
                    n_state       = ST_MINIT;
                end
            end
            ST_MINIT: begin
                w_cmd.mul_init = 1'b1;
                w_cmd.mul_base = !r_sq;
                n_step_cnt     = CW'(WIDTH - 1);
                n_state        = ST_MRUN;
            end
            ST_MRUN: begin
                w_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt - 1'b1;
                if (r_step_cnt == '0) begin
                    w_cmd.acc_wr = 1'b1;
                    if (r_sq && i_sts.exp_msb) begin
                        n_sq    = 1'b0;
                        n_state = ST_MINIT;
                    end else begin
                        w_cmd.exp_shift = 1'b1;
                        n_sq            = 1'b1;
                        n_bit_cnt       = r_bit_cnt - 1'b1;
                        n_state         = (r_bit_cnt == '0) ? ST_FIN : ST_MINIT;
                    end
                end
            end
            ST_FIN: begin
                // output register free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.res_wr = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step_cnt  <= '0;
            r_bit_cnt   <= '0;
            r_sq        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step_cnt  <= n_step_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_sq        <= n_sq;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by square-and-multiply, bit-serial products.
// ----------------------------------------------------------------------------
// Throughput: one beat at a time; the shared double-and-add step (one
//   multiplier bit per cycle) sets the rate.
// The result register frees the input side while a result waits.
// Synchronous active-low reset: idle, no result pending, modulus = 7.
module modular_exponentiation #(
    parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [modexp_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [2*modexp_pkg::DATA_W-1:0] s_axis_tdata,  // base_value, exponent_value
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [modexp_pkg::DATA_W-1:0]   m_axis_tdata   // power_residue
);
    import modexp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    modexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    modexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_base      (s_axis_tdata[DATA_W-1:0]),
        .i_exp       (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res       (m_axis_tdata)
    );

endmodule

FILE: rtl/modexp_chk.sv
// ----------------------------------------------------------------------------
// modexp_chk
// Port-level checks for the modular exponentiation block.
// ----------------------------------------------------------------------------
module modexp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // pending result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // one item in flight: input closes after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a new result only appears at the end of a computation
    a_res_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a computation");

    // reset leaves the block idle with nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind modular_exponentiation modexp_chk u_modexp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/modexp_checker.sv
// ----------------------------------------------------------------------------
// modexp_checker
// Passive monitor for modular_exponentiation. It tracks the modulus register
// from the config port and computes base ^ exponent mod modulus for every
// input beat. Each output beat is compared in order against the oldest
// predicted residue.
// ----------------------------------------------------------------------------
module modexp_checker
    import modexp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DATA_W-1:0]     i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [2*DATA_W-1:0]   i_in_data,    // base_value, exponent_value
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [DATA_W-1:0]     i_out_data,   // power_residue
    output int                    o_pending,
    output int                    o_errors
);

    logic [DATA_W-1:0] modulus = MODULUS_RESET;
    logic [DATA_W-1:0] residue_q[$];

    // Square-and-multiply, MSB first. Products of two residues fit in 2*DATA_W bits.
    function automatic logic [DATA_W-1:0] power_mod(input logic [DATA_W-1:0] base,
                                                    input logic [DATA_W-1:0] expo,
                                                    input logic [DATA_W-1:0] m_in);
        logic [2*DATA_W-1:0] m;
        logic [2*DATA_W-1:0] b;
        logic [2*DATA_W-1:0] acc;
        if (m_in < 2)
            return '0;   // modulus 0 or 1: no residue other than 0
        m   = {{DATA_W{1'b0}}, m_in};
        b   = {{DATA_W{1'b0}}, base} % m;
        acc = (2*DATA_W)'(1);
        for (int i = DATA_W - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (expo[i])
                acc = (acc * b) % m;
        end
        return acc[DATA_W-1:0];
    endfunction

    task automatic note_failure(input string what);
        o_errors++;
        if (o_errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            modulus = MODULUS_RESET;
            residue_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                residue_q.push_back(power_mod(i_in_data[DATA_W-1:0],
                                              i_in_data[2*DATA_W-1:DATA_W], modulus));
            if (i_out_valid && i_out_ready) begin
                if (residue_q.size() == 0) begin
                    note_failure($sformatf("unexpected result beat, power_residue=%0h",
                                           i_out_data));
                end else begin
                    want = residue_q.pop_front();
                    if (i_out_data !== want)
                        note_failure($sformatf("power_residue expected %0h actual %0h",
                                               want, i_out_data));
                end
            end
            // register takes effect for beats accepted after this edge
            if (i_cfg_we)
                modulus = i_cfg_wdata;
        end
        o_pending = residue_q.size();
    end

endmodule

FILE: tb/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Stimulus and verdict for modular_exponentiation. Directed corner operands
// under several moduli (reset value, 0, 1, 2, all ones, largest 32-bit prime)
// are followed by random phases, each under a fresh modulus written while the
// block is drained. Both stream sides idle in short random bursts except in
// the final phase; modexp_checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
    import modexp_pkg::*;

    localparam int          STALL_LIMIT  = 20000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [31:0] PRIME_MAX    = 32'hFFFF_FFFB;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [DATA_W-1:0]     i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [2*DATA_W-1:0]   s_axis_tdata;   // base_value, exponent_value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;   // power_residue

    int                    pending;
    int                    errors;
    int                    quiet_cycles = 0;
    int                    stall_left = 0;
    logic                  idle_on = 1'b1;
    logic [DATA_W-1:0]     cur_modulus = MODULUS_RESET;

    always #5 i_clk = ~i_clk;

    modular_exponentiation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    modexp_checker residue_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left    <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: no beat moved on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] expo);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {expo, base};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // sender holds off until every predicted residue has come back
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [DATA_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cur_modulus = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_base;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 15);
            1:       return cur_modulus + $urandom_range(0, 2) - 1;   // around the modulus
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_exponent;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(1, 5);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input logic [DATA_W-1:0] value, input int count);
        write_modulus(value);
        repeat (count) send_beat(pick_base(), pick_exponent());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus of 7
        send_beat(32'd0, 32'd0);
        send_beat(32'd0, 32'd5);
        send_beat(32'd10, 32'd3);
        send_beat(32'd7, 32'd1);
        send_beat(32'd3, 32'd6);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'd2, 32'd0);
        // degenerate moduli 0 and 1 give 0, then moduli 2 and all ones
        write_modulus(32'd0);
        send_beat(32'd5, 32'd3);
        send_beat(32'hFFFF_FFFF, 32'd0);
        write_modulus(32'd1);
        send_beat(32'd5, 32'd3);
        send_beat(32'd0, 32'd0);
        write_modulus(32'd2);
        send_beat(32'd3, 32'hFFFF_FFFF);
        send_beat(32'd0, 32'd0);
        write_modulus(32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'd1);
        send_beat(32'hFFFF_FFFE, 32'd2);
        send_beat(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        // largest 32-bit prime, Fermat case gives 1
        write_modulus(PRIME_MAX);
        send_beat(32'd5, PRIME_MAX - 1);
        send_beat(PRIME_MAX - 1, 32'd2);
        send_beat(PRIME_MAX, 32'd7);
        send_beat(32'd1, 32'hFFFF_FFFF);

        random_phase(PRIME_MAX, 60);
        random_phase($urandom_range(32'hFFFF_FFFF, 32'd2), 50);
        random_phase($urandom_range(1000, 3), 40);
        random_phase(32'd2, 20);
        random_phase(32'hFFFF_FFFF, 40);
        random_phase(32'd1, 10);
        drain();
        idle_on = 1'b0;
        random_phase($urandom, 60);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
